>>> sv/spq_pkg.sv
// spq_pkg: sizes, command codes and the entry and control types of the sorted priority queue.
// No dependencies. The interfaces, spq_cell and sorted_priority_queue import it.
package spq_pkg;

	// queue geometry
	localparam int DEPTH     = 16;
	localparam int KEY_BITS  = 16;
	localparam int DATA_BITS = 16;
	localparam int CNT_W     = $clog2(DEPTH + 1);

	// fixed field widths on the channels
	localparam int CMD_FW   = 2;
	localparam int KEY_FW   = 16;
	localparam int DATA_FW  = 16;
	localparam int COUNT_FW = 5;

	typedef enum logic [CMD_FW-1:0] {
		CMD_INSERT = 2'd0,
		CMD_POP    = 2'd1,
		CMD_NOP    = 2'd2
	} spq_cmd_t;

	typedef struct packed {
		logic [KEY_BITS-1:0]  key;
		logic [DATA_BITS-1:0] data;
	} spq_ent_t;

	// per-cell control from the top level
	typedef struct packed {
		logic ins;   // an insert that is not refused
		logic pop;   // a pop on a non-empty queue
		logic occ;   // cell holds a live entry
		logic tail;  // cell is the first free slot
		logic head;  // cell 0: equal keys go behind it
	} spq_ctl_t;

endpackage

>>> sv/spq_req_if.sv
// spq_req_if: request channel of the sorted priority queue (valid/ready plus command fields).
// Depends on spq_pkg.
interface spq_req_if;
	import spq_pkg::*;

	logic                valid;
	logic                ready;
	logic [CMD_FW-1:0]   cmd;
	logic [KEY_FW-1:0]   key_value;
	logic [DATA_FW-1:0]  payload;

	modport source (output valid, output cmd, output key_value, output payload, input ready);
	modport sink   (input valid, input cmd, input key_value, input payload, output ready);
endinterface

>>> sv/spq_rsp_if.sv
// spq_rsp_if: status channel of the sorted priority queue (valid/ready plus head and count).
// Depends on spq_pkg.
interface spq_rsp_if;
	import spq_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 head_valid;
	logic [KEY_FW-1:0]    head_key;
	logic [DATA_FW-1:0]   head_payload;
	logic [COUNT_FW-1:0]  entry_count;
	logic                 refused;

	modport source (output valid, output head_valid, output head_key, output head_payload,
		output entry_count, output refused, input ready);
	modport sink   (input valid, input head_valid, input head_key, input head_payload,
		input entry_count, input refused, output ready);
endinterface

>>> sv/sorted_priority_queue.sv
// sorted_priority_queue: top level, a row of spq_cell slots kept in ascending key order.
// Depends on spq_pkg, spq_req_if, spq_rsp_if and spq_cell.
//
//  channel | modport | fields                                                   | meaning
//  --------+---------+----------------------------------------------------------+-------------------
//  req     | sink    | cmd, key_value, payload                                  | insert / pop / nop
//  rsp     | source  | head_valid, head_key, head_payload, entry_count, refused | status after request
//
// One request per cycle unless rsp stalls: each cell compares its key with the incoming key at once;
// on the accepting edge an insert shifts the slots from its place on right, a pop the whole row left.
// The status is registered; a request is taken whenever the status register is empty
// or is being drained in the same cycle, so a stalled rsp stalls req after one item.
// arst_n clears the fill count and the status valid; slot contents are not reset.
module sorted_priority_queue (
	input  logic      clk,
	input  logic      arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);
	import spq_pkg::*;

	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_nxt;
	logic             rsp_valid_q;
	logic             head_valid_q;
	logic [KEY_FW-1:0]   head_key_q;
	logic [DATA_FW-1:0]  head_payload_q;
	logic [COUNT_FW-1:0] entry_count_q;
	logic             refused_q;

	logic     acc;
	logic     is_ins;
	logic     is_pop;
	logic     full;
	logic     ins_go;
	logic     pop_go;
	spq_ent_t new_ent;

	spq_ent_t ent [DEPTH];
	spq_ent_t nxt [DEPTH];
	logic     gb  [DEPTH];

	// request handshake: the status register parts the two sides
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign acc       = req.valid && req.ready;

	always_comb begin
		is_ins = 1'b0;
		is_pop = 1'b0;
		case (req.cmd)
			CMD_INSERT: is_ins = 1'b1;
			CMD_POP:    is_pop = 1'b1;
			default:    ;  // no operation, unused code included
		endcase
	end

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign ins_go  = acc && is_ins && !full;
	assign pop_go  = acc && is_pop && (cnt_q != '0);
	assign new_ent = '{key: KEY_BITS'(req.key_value), data: DATA_BITS'(req.payload)};

	always_comb begin
		cnt_nxt = cnt_q;
		if (ins_go) begin
			cnt_nxt = cnt_q + CNT_W'(1);
		end else if (pop_go) begin
			cnt_nxt = cnt_q - CNT_W'(1);
		end
	end

	// the row of slots; slot i is live when i < count
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		spq_ctl_t ctl;
		spq_ent_t left_ent;
		spq_ent_t right_ent;
		logic     left_gb;

		assign ctl.ins  = ins_go;
		assign ctl.pop  = pop_go;
		assign ctl.occ  = (CNT_W'(i) < cnt_q);
		assign ctl.tail = (CNT_W'(i) == cnt_q);
		assign ctl.head = (i == 0);

		if (i == 0) begin : g_first
			assign left_ent = new_ent;
			assign left_gb  = 1'b0;
		end else begin : g_mid
			assign left_ent = ent[i-1];
			assign left_gb  = gb[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_ent = ent[i];
		end else begin : g_inner
			assign right_ent = ent[i+1];
		end

		spq_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.new_ent   (new_ent),
			.left_ent  (left_ent),
			.right_ent (right_ent),
			.left_gb   (left_gb),
			.gb        (gb[i]),
			.ent       (ent[i]),
			.nxt       (nxt[i])
		);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_nxt;
			if (acc) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// status payload, taken from the state after the request
	always_ff @(posedge clk) begin
		if (acc) begin
			head_valid_q   <= (cnt_nxt != '0);
			head_key_q     <= (cnt_nxt != '0) ? KEY_FW'(nxt[0].key) : '0;
			head_payload_q <= (cnt_nxt != '0) ? DATA_FW'(nxt[0].data) : '0;
			entry_count_q  <= COUNT_FW'(cnt_nxt);
			refused_q      <= is_ins && full;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.head_valid   = head_valid_q;
	assign rsp.head_key     = head_key_q;
	assign rsp.head_payload = head_payload_q;
	assign rsp.entry_count  = entry_count_q;
	assign rsp.refused      = refused_q;

	// checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("fill count beyond depth");

	a_ins_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && is_ins && !full) |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
		else $error("accepted insert did not grow the queue");

	a_head_order: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q >= CNT_W'(2)) |-> (ent[0].key <= ent[1].key))
		else $error("head and second slot out of order");

	a_refuse_full: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && is_ins && full) |=> (cnt_q == CNT_W'(DEPTH) && refused_q))
		else $error("insert into full queue not refused");

endmodule

>>> sv/spq_cell.sv
// spq_cell: one slot of the sorted shift-register queue; compares keys, then shifts, loads or holds.
// Depends on spq_pkg.
module spq_cell (
	input  logic              clk,
	input  spq_pkg::spq_ctl_t ctl,
	input  spq_pkg::spq_ent_t new_ent,
	input  spq_pkg::spq_ent_t left_ent,
	input  spq_pkg::spq_ent_t right_ent,
	input  logic              left_gb,
	output logic              gb,
	output spq_pkg::spq_ent_t ent,
	output spq_pkg::spq_ent_t nxt
);
	import spq_pkg::*;

	spq_ent_t ent_q;

	// new entry belongs at or before this slot
	always_comb begin
		if (ctl.head) begin
			gb = ctl.occ && (new_ent.key < ent_q.key);
		end else begin
			gb = ctl.occ && (new_ent.key <= ent_q.key);
		end
	end

	always_comb begin
		nxt = ent_q;
		if (ctl.ins) begin
			if (left_gb) begin
				nxt = left_ent;
			end else if (gb || ctl.tail) begin
				nxt = new_ent;
			end
		end else if (ctl.pop) begin
			nxt = right_ent;
		end
	end

	always_ff @(posedge clk) begin
		ent_q <= nxt;
	end

	assign ent = ent_q;

endmodule

>>> sim/tb_top.sv
// tb_top: self-checking bench for sorted_priority_queue (directed table, then random traffic).
// Depends on spq_pkg, spq_req_if, spq_rsp_if and the RTL of sorted_priority_queue.
`timescale 1ns / 100ps

module tb_top;
	import spq_pkg::*;

	// cmd code 3 has no enum member; the queue must treat it as a status-only request
	localparam logic [CMD_FW-1:0] CMD_SPARE = 2'd3;

	localparam int RANDOM_REQS    = 1620;
	localparam int WATCHDOG_LIMIT = 2000;  // far above longest gap plus longest stall

	typedef struct packed {
		logic                head_valid;
		logic [KEY_FW-1:0]   head_key;
		logic [DATA_FW-1:0]  head_payload;
		logic [COUNT_FW-1:0] entry_count;
		logic                refused;
	} status_t;

	// one row of the directed table; typed rows carry a hand-written expectation
	typedef struct {
		logic [CMD_FW-1:0]  cmd;
		logic [KEY_FW-1:0]  key;
		logic [DATA_FW-1:0] payload;
		bit                 typed;
		status_t            want;
	} req_row_t;

	logic clk;
	logic arst_n;

	spq_req_if req_bus ();
	spq_rsp_if rsp_bus ();

	sorted_priority_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	// ---------------------------------------------------------------
	// Shadow of the queue contents, updated on every accepted request
	// ---------------------------------------------------------------
	spq_ent_t model_ent [DEPTH];
	int       model_fill;

	status_t  pending_status [$];   // status words owed by the queue, oldest first
	req_row_t directed_rows [$];

	// request-side tags that travel with the request currently on the bus
	bit       cur_typed;
	status_t  cur_want;
	bit       calm;                 // segment with no idling on either side

	int errors        = 0;
	int sent_reqs     = 0;
	int accepted_reqs = 0;
	int status_seen   = 0;
	int idle_cycles   = 0;
	int n_refused     = 0;
	int n_empty_pops  = 0;
	int n_head_ties   = 0;
	int n_full        = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Next status of the queue for one request. Inserts go before the first
	// entry with a key not below the new one, except that a key equal to the
	// head's lands right behind the head.
	function automatic status_t queue_step(input logic [CMD_FW-1:0] op,
		input logic [KEY_FW-1:0] k, input logic [DATA_FW-1:0] d);
		status_t  s;
		spq_ent_t e;
		int       pos;
		int       i;
		e.key     = k[KEY_BITS-1:0];
		e.data    = d[DATA_BITS-1:0];
		s.refused = 1'b0;
		if (op == CMD_INSERT) begin
			if (model_fill >= DEPTH) begin
				s.refused = 1'b1;
				n_refused++;
			end else begin
				if (model_fill == 0 || e.key < model_ent[0].key) begin
					pos = 0;
				end else begin
					if (e.key == model_ent[0].key)
						n_head_ties++;
					pos = 1;
					while (pos < model_fill && model_ent[pos].key < e.key)
						pos++;
				end
				for (i = model_fill; i > pos; i--)
					model_ent[i] = model_ent[i-1];
				model_ent[pos] = e;
				model_fill++;
				if (model_fill == DEPTH)
					n_full++;
			end
		end else if (op == CMD_POP) begin
			if (model_fill > 0) begin
				for (i = 0; i + 1 < model_fill; i++)
					model_ent[i] = model_ent[i+1];
				model_fill--;
			end else begin
				n_empty_pops++;
			end
		end
		// NOP and the spare code leave the contents alone
		s.head_valid   = (model_fill > 0);
		s.head_key     = s.head_valid ? KEY_FW'(model_ent[0].key) : '0;
		s.head_payload = s.head_valid ? DATA_FW'(model_ent[0].data) : '0;
		s.entry_count  = COUNT_FW'(model_fill);
		return s;
	endfunction

	function automatic status_t mk_status(input logic hv, input logic [KEY_FW-1:0] k,
		input logic [DATA_FW-1:0] p, input int cnt, input logic r);
		status_t s;
		s.head_valid   = hv;
		s.head_key     = k;
		s.head_payload = p;
		s.entry_count  = COUNT_FW'(cnt);
		s.refused      = r;
		return s;
	endfunction

	function automatic req_row_t mk_row(input logic [CMD_FW-1:0] c, input logic [KEY_FW-1:0] k,
		input logic [DATA_FW-1:0] p, input bit typed, input status_t want);
		req_row_t r;
		r.cmd     = c;
		r.key     = k;
		r.payload = p;
		r.typed   = typed;
		r.want    = want;
		return r;
	endfunction

	// mostly back-to-back, sometimes short holes, rarely long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		errors++;
		$display("mismatch: %s got %0h want %0h (status word %0d, t=%0t)",
			what, got, want, status_seen, $realtime);
	endtask

	// Directed table: reset state, an empty pop, extremes, the head tie, the spare
	// code, then a fill to the brim and an insert that must bounce.
	task automatic load_directed();
		status_t empty_st;
		status_t none;
		int      i;
		empty_st = mk_status(1'b0, '0, '0, 0, 1'b0);
		none     = '0;
		directed_rows.push_back(mk_row(CMD_NOP,    16'h0000, 16'h0000, 1, empty_st));
		directed_rows.push_back(mk_row(CMD_POP,    16'hFFFF, 16'hFFFF, 1, empty_st));
		directed_rows.push_back(mk_row(CMD_INSERT, 16'hFFFF, 16'hFFFF, 1,
			mk_status(1'b1, 16'hFFFF, 16'hFFFF, 1, 1'b0)));
		directed_rows.push_back(mk_row(CMD_INSERT, 16'h0000, 16'h0000, 1,
			mk_status(1'b1, 16'h0000, 16'h0000, 2, 1'b0)));
		// same key as the head: goes behind it, head payload unchanged
		directed_rows.push_back(mk_row(CMD_INSERT, 16'h0000, 16'hA5A5, 1,
			mk_status(1'b1, 16'h0000, 16'h0000, 3, 1'b0)));
		directed_rows.push_back(mk_row(CMD_POP,    16'h0000, 16'h0000, 1,
			mk_status(1'b1, 16'h0000, 16'hA5A5, 2, 1'b0)));
		directed_rows.push_back(mk_row(CMD_POP,    16'h0000, 16'h0000, 1,
			mk_status(1'b1, 16'hFFFF, 16'hFFFF, 1, 1'b0)));
		directed_rows.push_back(mk_row(CMD_POP,    16'h0000, 16'h0000, 1, empty_st));
		directed_rows.push_back(mk_row(CMD_SPARE,  16'h1234, 16'h5678, 1, empty_st));
		directed_rows.push_back(mk_row(CMD_INSERT, 16'h8000, 16'h5A5A, 1,
			mk_status(1'b1, 16'h8000, 16'h5A5A, 1, 1'b0)));
		directed_rows.push_back(mk_row(CMD_POP,    16'h7FFF, 16'h0001, 1, empty_st));
		// scrambled keys 0x1000..0x10F0, checked by the shadow queue
		for (i = 0; i < DEPTH; i++)
			directed_rows.push_back(mk_row(CMD_INSERT, 16'h1000 + 16'(((i * 7) % 16) * 16),
				16'hC000 | 16'(i), 0, none));
		// full: even the smallest key is turned away
		directed_rows.push_back(mk_row(CMD_INSERT, 16'h0000, 16'hFFFF, 1,
			mk_status(1'b1, 16'h1000, 16'hC000, DEPTH, 1'b1)));
	endtask

	// Drive one request: optional idle hole, then hold valid until ready.
	task automatic send_row(input req_row_t row);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_bus.valid     <= 1'b1;
		req_bus.cmd       <= row.cmd;
		req_bus.key_value <= row.key;
		req_bus.payload   <= row.payload;
		cur_typed         <= row.typed;
		cur_want          <= row.want;
		do @(posedge clk); while (!req_bus.ready);
		sent_reqs++;
	endtask

	// ---------------------------------------------------------------
	// Monitor: both handshakes are sampled at the edge that completes them
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		status_t got;
		status_t want;
		status_t next_st;
		bit      moved;
		if (arst_n) begin
			moved = 1'b0;
			if (rsp_bus.valid && rsp_bus.ready) begin
				moved = 1'b1;
				status_seen++;
				got = {rsp_bus.head_valid, rsp_bus.head_key, rsp_bus.head_payload,
					rsp_bus.entry_count, rsp_bus.refused};
				if (pending_status.size() == 0) begin
					report_mismatch("status with no request behind it", 64'(got), 64'h0);
				end else begin
					want = pending_status.pop_front();
					if (got.head_valid !== want.head_valid)
						report_mismatch("head_valid", 64'(got.head_valid), 64'(want.head_valid));
					if (got.head_key !== want.head_key)
						report_mismatch("head_key", 64'(got.head_key), 64'(want.head_key));
					if (got.head_payload !== want.head_payload)
						report_mismatch("head_payload", 64'(got.head_payload),
							64'(want.head_payload));
					if (got.entry_count !== want.entry_count)
						report_mismatch("entry_count", 64'(got.entry_count),
							64'(want.entry_count));
					if (got.refused !== want.refused)
						report_mismatch("refused", 64'(got.refused), 64'(want.refused));
				end
			end
			if (req_bus.valid && req_bus.ready) begin
				moved = 1'b1;
				accepted_reqs++;
				next_st = queue_step(req_bus.cmd, req_bus.key_value, req_bus.payload);
				pending_status.push_back(cur_typed ? cur_want : next_st);
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
		end
	end

	// Watchdog: too long with nothing moving on either channel
	initial begin
		while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("watchdog: no handshake for %0d cycles, %0d status words outstanding",
			WATCHDOG_LIMIT, pending_status.size());
		$display("status: fail");
		$finish;
	end

	// Status sink: ready drops for random stretches unless the segment is calm
	initial begin
		int low_len;
		rsp_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			low_len = calm ? 0 : pick_gap();
			if (low_len > 0) begin
				rsp_bus.ready <= 1'b0;
				repeat (low_len) @(posedge clk);
			end
			rsp_bus.ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
	end

	// ---------------------------------------------------------------
	// Request source: directed table, then random segments
	// ---------------------------------------------------------------
	initial begin
		int       seg_left;
		int       ins_pct;
		int       key_mode;
		int       r;
		int       n;
		int       i;
		logic [KEY_FW-1:0] seg_base;
		req_row_t row;
		int       pct_menu [5];

		pct_menu = '{10, 30, 50, 70, 90};
		seg_left = 0;
		ins_pct  = 50;
		key_mode = 0;
		seg_base = '0;
		calm     = 1'b0;

		arst_n            <= 1'b0;
		req_bus.valid     <= 1'b0;
		req_bus.cmd       <= CMD_NOP;
		req_bus.key_value <= '0;
		req_bus.payload   <= '0;
		cur_typed         <= 1'b0;
		cur_want          <= '0;

		load_directed();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < directed_rows.size(); i++)
			send_row(directed_rows[i]);

		// Random part: segments with their own insert/pop mix and key style, so the
		// queue swings between empty and full and sees runs of equal keys.
		for (n = 0; n < RANDOM_REQS; n++) begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(30, 120);
				ins_pct  = pct_menu[$urandom_range(0, 4)];
				key_mode = $urandom_range(0, 3);
				seg_base = KEY_FW'($urandom_range(0, 16'hFFF0));
				calm     = ($urandom_range(0, 4) == 0);
			end
			seg_left--;
			r = $urandom_range(0, 99);
			if (r < 3)
				row.cmd = ($urandom_range(0, 1) == 0) ? CMD_NOP : CMD_SPARE;
			else if (r < 3 + (ins_pct * 97) / 100)
				row.cmd = CMD_INSERT;
			else
				row.cmd = CMD_POP;
			case (key_mode)
				0: begin
					row.key = KEY_FW'($urandom_range(0, 16'hFFFF));
				end
				1: begin
					// tiny key range: ties with the head and deep ties are common
					row.key = KEY_FW'($urandom_range(0, 7));
				end
				2: begin
					case ($urandom_range(0, 3))
						0: row.key = 16'h0000;
						1: row.key = 16'h0001;
						2: row.key = 16'hFFFE;
						default: row.key = 16'hFFFF;
					endcase
				end
				default: begin
					row.key = seg_base + KEY_FW'($urandom_range(0, 15));
				end
			endcase
			row.payload = DATA_FW'($urandom_range(0, 16'hFFFF));
			row.typed   = 1'b0;
			row.want    = '0;
			send_row(row);
		end
		req_bus.valid <= 1'b0;

		// drain: every request accounted for and every status word back
		while (accepted_reqs != sent_reqs || pending_status.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);

		$display("ran %0d requests (%0d from the table), %0d status words checked",
			accepted_reqs, directed_rows.size(), status_seen);
		$display("refused inserts %0d, pops on empty %0d, head-key ties %0d, fills to full %0d",
			n_refused, n_empty_pops, n_head_ties, n_full);
		if (errors == 0 && pending_status.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> filelist.f
sv/spq_pkg.sv
sv/spq_req_if.sv
sv/spq_rsp_if.sv
sv/spq_cell.sv
sv/sorted_priority_queue.sv
sim/tb_top.sv
